[rtl/spqws_pkg.sv]
// Shared types and constants of the stable priority queue with wait statistics.
// No dependencies; used by every module of the block.
package spqws_pkg;

  localparam int unsigned DefQueueDepth = 64;
  localparam int unsigned SevW          = 4;
  localparam int unsigned IdW           = 16;
  localparam int unsigned TimeW         = 32;
  localparam int unsigned OccW          = 7;
  localparam int unsigned InDataW       = 56;
  localparam int unsigned OutDataW      = 128;
  localparam int unsigned InPackedW     = SevW + IdW + TimeW;
  localparam int unsigned OutPackedW    = IdW + SevW + 3 * TimeW + OccW;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // One stored item
  typedef struct packed {
    logic [IdW-1:0]   id;
    logic [SevW-1:0]  sev;
    logic [TimeW-1:0] t_in;
  } entry_t;

  // Classified request from the front end
  typedef struct packed {
    op_e              op;
    logic [SevW-1:0]  sev;
    logic [IdW-1:0]   id;
    logic [TimeW-1:0] now;
  } req_t;

  // Result of the queue operation, before statistics
  typedef struct packed {
    status_e          status;
    logic             served;
    logic [IdW-1:0]   id;
    logic [SevW-1:0]  sev;
    logic [TimeW-1:0] wait_time;
    logic [OccW-1:0]  occupancy;
  } exec_t;

  // Complete result item
  typedef struct packed {
    status_e          status;
    logic [IdW-1:0]   id;
    logic [SevW-1:0]  sev;
    logic [TimeW-1:0] wait_time;
    logic [TimeW-1:0] total_wait;
    logic [TimeW-1:0] total_served;
    logic [OccW-1:0]  occupancy;
  } result_t;

endpackage

[rtl/spqws_front.sv]
// Front end: accepts request transfers, decodes them and buffers them in a
// two-entry queue. Depends on spqws_pkg.
module spqws_front
  import spqws_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [InDataW-1:0] s_axis_tdata,
  input  logic               s_axis_tuser,
  output logic               req_valid_o,
  input  logic               req_ready_i,
  output req_t               req_o
);

  req_t       buf_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;
  req_t       req_in;

  // Decode the transfer into a request
  always_comb begin
    req_in.op  = op_e'(s_axis_tuser);
    req_in.sev = s_axis_tdata[SevW-1:0];
    req_in.id  = s_axis_tdata[SevW +: IdW];
    req_in.now = s_axis_tdata[SevW+IdW +: TimeW];
  end

  assign s_axis_tready = (cnt_q != 2'd2);
  assign push          = s_axis_tvalid && s_axis_tready;
  assign req_valid_o   = (cnt_q != 2'd0);
  assign pop           = req_valid_o && req_ready_i;
  assign req_o         = buf_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wr_ptr_q] <= req_in;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q != 2'd3)
    else $error("front queue count out of range");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (push && !pop) |=> (cnt_q == $past(cnt_q) + 2'd1))
    else $error("front queue count missed a push");

endmodule

[rtl/spqws_cells.sv]
// Back end queue: a row of insertion cells kept in service order, head at
// cell 0, with the fill count. Computes the wait of a removed item.
// Depends on spqws_pkg.
module spqws_cells
  import spqws_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = DefQueueDepth
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  req_valid_i,
  output logic  req_ready_o,
  input  req_t  req_i,
  output logic  ex_valid_o,
  input  logic  ex_ready_i,
  output exec_t ex_o
);

  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  entry_t            cells_q [QUEUE_DEPTH];
  logic [CntW-1:0]   count_q, count_d;
  logic [QUEUE_DEPTH-1:0] behind;
  logic              fire, is_full, is_empty, do_ins, do_rem;
  entry_t            new_entry;
  exec_t             ex_d, ex_q;
  logic              ex_valid_q;

  assign req_ready_o = !ex_valid_q || ex_ready_i;
  assign fire        = req_valid_i && req_ready_o;
  assign is_full     = (count_q == CntW'(QUEUE_DEPTH));
  assign is_empty    = (count_q == '0);
  assign do_ins      = fire && (req_i.op == OP_INSERT) && !is_full;
  assign do_rem      = fire && (req_i.op == OP_REMOVE) && !is_empty;

  assign new_entry.id   = req_i.id;
  assign new_entry.sev  = req_i.sev;
  assign new_entry.t_in = req_i.now;

  // Each occupied cell of equal or higher severity keeps its place
  for (genvar k = 0; k < QUEUE_DEPTH; k++) begin : g_cmp
    assign behind[k] = (CntW'(k) < count_q) && (cells_q[k].sev >= req_i.sev);
  end

  for (genvar k = 0; k < QUEUE_DEPTH; k++) begin : g_cell
    always_ff @(posedge clk_i) begin
      if (do_ins && !behind[k]) begin
        if (k == 0) begin
          cells_q[k] <= new_entry;
        end else if (behind[(k == 0) ? 0 : k-1]) begin
          cells_q[k] <= new_entry;
        end else begin
          cells_q[k] <= cells_q[(k == 0) ? 0 : k-1];
        end
      end else if (do_rem && (k < QUEUE_DEPTH - 1)) begin
        cells_q[k] <= cells_q[(k < QUEUE_DEPTH - 1) ? k+1 : k];
      end
    end
  end

  always_comb begin
    count_d = count_q;
    if (do_ins) begin
      count_d = count_q + CntW'(1);
    end else if (do_rem) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_comb begin
    ex_d           = '0;
    ex_d.status    = ST_OK;
    ex_d.occupancy = OccW'(count_d);
    unique case (req_i.op)
      OP_INSERT: begin
        if (is_full) begin
          ex_d.status = ST_FULL;
        end
      end
      OP_REMOVE: begin
        if (is_empty) begin
          ex_d.status = ST_EMPTY;
        end else begin
          ex_d.served    = 1'b1;
          ex_d.id        = cells_q[0].id;
          ex_d.sev       = cells_q[0].sev;
          ex_d.wait_time = req_i.now - cells_q[0].t_in;
        end
      end
      default: ex_d.status = ST_OK;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      ex_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (fire) begin
        ex_valid_q <= 1'b1;
      end else if (ex_ready_i) begin
        ex_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      ex_q <= ex_d;
    end
  end

  assign ex_valid_o = ex_valid_q;
  assign ex_o       = ex_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   count_q <= CntW'(QUEUE_DEPTH))
    else $error("fill count beyond queue depth");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   do_ins |=> (count_q == $past(count_q) + CntW'(1)))
    else $error("insert did not grow the queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (fire && !do_ins && !do_rem) |=> $stable(count_q))
    else $error("refused request changed the fill count");

endmodule

[rtl/spqws_stats.sv]
// Back end statistics: running wait sum and served count, and the output
// register toward the result channel. Depends on spqws_pkg.
module spqws_stats
  import spqws_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    ex_valid_i,
  output logic    ex_ready_o,
  input  exec_t   ex_i,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output result_t out_o
);

  logic [TimeW-1:0] total_wait_q, total_wait_d;
  logic [TimeW-1:0] total_served_q, total_served_d;
  logic             out_valid_q;
  result_t          out_q;
  logic             adv;

  assign ex_ready_o = !out_valid_q || out_ready_i;
  assign adv        = ex_valid_i && ex_ready_o;

  // Fold a served item into the totals
  always_comb begin
    total_wait_d   = total_wait_q;
    total_served_d = total_served_q;
    if (ex_i.served) begin
      total_wait_d   = total_wait_q + ex_i.wait_time;
      total_served_d = total_served_q + TimeW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_wait_q   <= '0;
      total_served_q <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      if (adv) begin
        total_wait_q   <= total_wait_d;
        total_served_q <= total_served_d;
        out_valid_q    <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q.status       <= ex_i.status;
      out_q.id           <= ex_i.id;
      out_q.sev          <= ex_i.sev;
      out_q.wait_time    <= ex_i.wait_time;
      out_q.total_wait   <= total_wait_d;
      out_q.total_served <= total_served_d;
      out_q.occupancy    <= ex_i.occupancy;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (adv && !ex_i.served) |=> $stable(total_served_q))
    else $error("served count moved without a served item");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (adv && ex_i.served) |=>
                   (total_served_q == $past(total_served_q) + TimeW'(1)))
    else $error("served item not counted");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (adv && ex_i.served) |-> (ex_i.status == ST_OK))
    else $error("served item with failing status");

endmodule

[rtl/stable_priority_queue_wait_stats.sv]
// Top level of the stable priority queue with wait statistics.
// Depends on spqws_pkg, spqws_front, spqws_cells and spqws_stats.
//
//  channel  dir  handshake      tdata                               tuser
//  s_axis   in   tvalid/tready  severity, item_id, now_time         req_type
//  m_axis   out  tvalid/tready  out_item_id .. occupancy (see port) status
//
// One request transfer gives exactly one result transfer, in order.
// Sustained rate is one request per cycle while the result channel is not stalled:
// the insertion cells compare every stored severity against the new one at once
// and shift in one step. Three register stages (front queue, cell update with wait
// subtract, totals accumulate into the output register) lie between a request
// transfer and its result.
// Reset clears the fill count, the totals and all handshake state; no sweep.
// A stalled result channel fills the output register, then the cell stage,
// then the two-entry front queue, and only then drops s_axis_tready.
module stable_priority_queue_wait_stats
  import spqws_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = DefQueueDepth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // [3:0] severity, [19:4] item_id, [51:20] now_time, [55:52] zero
  input  logic [InDataW-1:0]  s_axis_tdata,
  // [0] req_type
  input  logic                s_axis_tuser,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // [15:0] out_item_id, [19:16] out_severity, [51:20] wait_time,
  // [83:52] total_wait, [115:84] total_served, [122:116] occupancy, rest zero
  output logic [OutDataW-1:0] m_axis_tdata,
  // [1:0] status
  output logic [1:0]          m_axis_tuser
);

  // Front to back request queue
  logic    req_valid, req_ready;
  req_t    req;
  // Cell stage to statistics stage
  logic    ex_valid, ex_ready;
  exec_t   ex;
  // Registered result
  result_t res;

  // Accept and decode request transfers
  spqws_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .req_valid_o   (req_valid),
    .req_ready_i   (req_ready),
    .req_o         (req)
  );

  // Insert or remove in the ordered cell row
  spqws_cells #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_cells (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid),
    .req_ready_o (req_ready),
    .req_i       (req),
    .ex_valid_o  (ex_valid),
    .ex_ready_i  (ex_ready),
    .ex_o        (ex)
  );

  // Accumulate totals and hold the result
  spqws_stats u_stats (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ex_valid_i  (ex_valid),
    .ex_ready_o  (ex_ready),
    .ex_i        (ex),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_o       (res)
  );

  // Pack the result fields, lowest field first, zero fill to whole bytes
  assign m_axis_tdata = {(OutDataW - OutPackedW)'(0), res.occupancy, res.total_served,
                         res.total_wait, res.wait_time, res.sev, res.id};
  assign m_axis_tuser = res.status;

endmodule
